@@ rtl/tac_pkg.sv @@
// ----------------------------------------------------------------------------
// tac_pkg
// Shared types, codes and build-time constants of the threshold alarm
// controller.
// ----------------------------------------------------------------------------
package tac_pkg;

  // adc resolution of the air, light and soil channels
  localparam int ADC_BITS = 12;
  localparam int TEMP_W   = 8;
  localparam int HUMI_W   = 7;
  localparam int DELTA_W  = 8;

  // delta times ten spans -1280..1270
  localparam int STEP_W    = 12;
  // adc threshold plus scaled step, signed
  localparam int ADC_SUM_W = ((ADC_BITS + 1 > STEP_W) ? ADC_BITS + 1 : STEP_W) + 1;
  // temperature or humidity threshold plus delta, signed
  localparam int NARROW_SUM_W = TEMP_W + 1;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = (ADC_BITS > TEMP_W) ? ADC_BITS : TEMP_W;

  typedef enum logic [1:0] {
    CMD_SENSOR    = 2'd0,
    CMD_NEXT_PAGE = 2'd1,
    CMD_NEXT_ITEM = 2'd2,
    CMD_ADJUST    = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    PAGE_VALUES     = 4'd0,
    PAGE_THRESHOLDS = 4'd1,
    PAGE_TEMP_LO    = 4'd2,
    PAGE_TEMP_HI    = 4'd3,
    PAGE_HUMI_LO    = 4'd4,
    PAGE_HUMI_HI    = 4'd5,
    PAGE_AIR_MAX    = 4'd6,
    PAGE_LIGHT_LO   = 4'd7,
    PAGE_SOIL_LO    = 4'd8
  } page_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TEMP_FLOOR   = 3'd0,
    REG_TEMP_CEILING = 3'd1,
    REG_HUMI_FLOOR   = 3'd2,
    REG_HUMI_CEILING = 3'd3,
    REG_ADC_FLOOR    = 3'd4,
    REG_ADC_CEILING  = 3'd5
  } cfg_reg_e;

  // register reset values
  localparam logic [TEMP_W-1:0]   RST_TEMP_FLOOR   = TEMP_W'(-40);
  localparam logic [TEMP_W-1:0]   RST_TEMP_CEILING = TEMP_W'(125);
  localparam logic [HUMI_W-1:0]   RST_HUMI_FLOOR   = HUMI_W'(0);
  localparam logic [HUMI_W-1:0]   RST_HUMI_CEILING = HUMI_W'(100);
  localparam logic [ADC_BITS-1:0] RST_ADC_FLOOR    = ADC_BITS'(0);
  localparam logic [ADC_BITS-1:0] RST_ADC_CEILING  = ADC_BITS'(4095);

  // threshold defaults
  localparam logic [TEMP_W-1:0]   DEF_TEMP_LO   = TEMP_W'(10);
  localparam logic [TEMP_W-1:0]   DEF_TEMP_HI   = TEMP_W'(35);
  localparam logic [HUMI_W-1:0]   DEF_HUMI_LO   = HUMI_W'(30);
  localparam logic [HUMI_W-1:0]   DEF_HUMI_HI   = HUMI_W'(80);
  localparam logic [ADC_BITS-1:0] DEF_AIR_MAX   = ADC_BITS'(2000);
  localparam logic [ADC_BITS-1:0] DEF_LIGHT_LO  = ADC_BITS'(1000);
  localparam logic [ADC_BITS-1:0] DEF_SOIL_LO   = ADC_BITS'(1500);

  // readings before the first sensor word
  localparam logic [TEMP_W-1:0]   RST_TEMP_READING  = TEMP_W'(25);
  localparam logic [HUMI_W-1:0]   RST_HUMI_READING  = HUMI_W'(55);
  localparam logic [ADC_BITS-1:0] RST_AIR_READING   = ADC_BITS'(300);
  localparam logic [ADC_BITS-1:0] RST_LIGHT_READING = ADC_BITS'(500);
  localparam logic [ADC_BITS-1:0] RST_SOIL_READING  = ADC_BITS'(500);

  typedef struct packed {
    cmd_e                command;
    logic [DELTA_W-1:0]  adjust_delta;
    logic [TEMP_W-1:0]   temperature;
    logic [HUMI_W-1:0]   humidity;
    logic [ADC_BITS-1:0] air_level;
    logic [ADC_BITS-1:0] light_level;
    logic [ADC_BITS-1:0] soil_moisture;
  } item_t;

  typedef struct packed {
    logic buzzer_on;
    logic lamp_relay;
    logic fan_relay;
    logic pump_relay;
    logic humi_low_led;
    logic humi_high_led;
    logic temp_low_led;
    logic temp_high_led;
  } flags_t;

  typedef struct packed {
    flags_t flags;
    page_e  page;
    logic   setting_mode;
  } result_t;

endpackage

@@ rtl/tac_in_stage.sv @@
// ----------------------------------------------------------------------------
// tac_in_stage
// Input register: holds one accepted word until the update stage takes it.
// ----------------------------------------------------------------------------
module tac_in_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  tac_pkg::item_t item_i,
  input  logic           advance_i,
  output logic           item_valid_o,
  output tac_pkg::item_t item_o
);

  logic           valid_q, valid_d;
  tac_pkg::item_t item_q;
  logic           in_fire;

  // room when empty or when the held word moves on this cycle
  assign in_ready_o = !valid_q || advance_i;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (in_fire) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q <= item_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

@@ rtl/tac_update.sv @@
// ----------------------------------------------------------------------------
// tac_update
// Controller state, limit registers and the one-pass update: readings, page
// step, threshold adjust with clamp, and the alarm flags of the new state.
// ----------------------------------------------------------------------------
module tac_update (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [tac_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [tac_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                             item_valid_i,
  input  logic                             advance_i,
  input  tac_pkg::item_t                   item_i,
  output tac_pkg::result_t                 result_o
);

  localparam int TW = tac_pkg::TEMP_W;
  localparam int HW = tac_pkg::HUMI_W;
  localparam int AW = tac_pkg::ADC_BITS;
  localparam int NW = tac_pkg::NARROW_SUM_W;
  localparam int SW = tac_pkg::ADC_SUM_W;

  function automatic logic signed [NW-1:0] clamp_narrow(
    input logic signed [NW-1:0] v,
    input logic signed [NW-1:0] lo,
    input logic signed [NW-1:0] hi
  );
    logic signed [NW-1:0] r;
    if (v < lo) begin
      r = lo;
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic signed [SW-1:0] clamp_adc(
    input logic signed [SW-1:0] v,
    input logic signed [SW-1:0] lo,
    input logic signed [SW-1:0] hi
  );
    logic signed [SW-1:0] r;
    if (v < lo) begin
      r = lo;
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // limit registers
  logic [TW-1:0] temp_floor_q, temp_ceiling_q;
  logic [HW-1:0] humi_floor_q, humi_ceiling_q;
  logic [AW-1:0] adc_floor_q, adc_ceiling_q;

  // controller state
  tac_pkg::page_e page_q, page_d;
  logic [TW-1:0]  temp_lo_q, temp_lo_d, temp_hi_q, temp_hi_d;
  logic [HW-1:0]  humi_lo_q, humi_lo_d, humi_hi_q, humi_hi_d;
  logic [AW-1:0]  air_max_q, air_max_d, light_lo_q, light_lo_d;
  logic [AW-1:0]  soil_lo_q, soil_lo_d;
  logic [TW-1:0]  temp_rd_q, temp_rd_d;
  logic [HW-1:0]  humi_rd_q, humi_rd_d;
  logic [AW-1:0]  air_rd_q, air_rd_d, light_rd_q, light_rd_d, soil_rd_q, soil_rd_d;

  logic                           fire;
  logic signed [NW-1:0]           delta_n;
  logic signed [tac_pkg::STEP_W-1:0] delta_w, step10;
  logic signed [NW-1:0]           temp_lo_new, temp_hi_new, humi_lo_new, humi_hi_new;
  logic signed [SW-1:0]           air_new, light_new, soil_new;
  logic signed [SW-1:0]           adc_lo, adc_hi;
  tac_pkg::flags_t                flags;

  assign cfg_ready_o = 1'b1;
  assign fire        = item_valid_i && advance_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_floor_q   <= tac_pkg::RST_TEMP_FLOOR;
      temp_ceiling_q <= tac_pkg::RST_TEMP_CEILING;
      humi_floor_q   <= tac_pkg::RST_HUMI_FLOOR;
      humi_ceiling_q <= tac_pkg::RST_HUMI_CEILING;
      adc_floor_q    <= tac_pkg::RST_ADC_FLOOR;
      adc_ceiling_q  <= tac_pkg::RST_ADC_CEILING;
    end else if (cfg_valid_i) begin
      case (tac_pkg::cfg_reg_e'(cfg_index_i))
        tac_pkg::REG_TEMP_FLOOR:   temp_floor_q   <= cfg_data_i[TW-1:0];
        tac_pkg::REG_TEMP_CEILING: temp_ceiling_q <= cfg_data_i[TW-1:0];
        tac_pkg::REG_HUMI_FLOOR:   humi_floor_q   <= cfg_data_i[HW-1:0];
        tac_pkg::REG_HUMI_CEILING: humi_ceiling_q <= cfg_data_i[HW-1:0];
        tac_pkg::REG_ADC_FLOOR:    adc_floor_q    <= cfg_data_i[AW-1:0];
        tac_pkg::REG_ADC_CEILING:  adc_ceiling_q  <= cfg_data_i[AW-1:0];
        default: ;
      endcase
    end
  end

  // step arithmetic
  assign delta_n = NW'($signed(item_i.adjust_delta));
  assign delta_w = tac_pkg::STEP_W'($signed(item_i.adjust_delta));
  // times ten as x8 + x2
  assign step10  = (delta_w <<< 3) + (delta_w <<< 1);

  assign adc_lo = $signed({{(SW-AW){1'b0}}, adc_floor_q});
  assign adc_hi = $signed({{(SW-AW){1'b0}}, adc_ceiling_q});

  assign temp_lo_new = clamp_narrow(NW'($signed(temp_lo_q)) + delta_n,
                                    NW'($signed(temp_floor_q)),
                                    NW'($signed(temp_hi_q)));
  assign temp_hi_new = clamp_narrow(NW'($signed(temp_hi_q)) + delta_n,
                                    NW'($signed(temp_lo_q)),
                                    NW'($signed(temp_ceiling_q)));
  assign humi_lo_new = clamp_narrow($signed({{(NW-HW){1'b0}}, humi_lo_q}) + delta_n,
                                    $signed({{(NW-HW){1'b0}}, humi_floor_q}),
                                    $signed({{(NW-HW){1'b0}}, humi_hi_q}));
  assign humi_hi_new = clamp_narrow($signed({{(NW-HW){1'b0}}, humi_hi_q}) + delta_n,
                                    $signed({{(NW-HW){1'b0}}, humi_lo_q}),
                                    $signed({{(NW-HW){1'b0}}, humi_ceiling_q}));
  assign air_new   = clamp_adc($signed({{(SW-AW){1'b0}}, air_max_q}) + SW'(step10),
                               adc_lo, adc_hi);
  assign light_new = clamp_adc($signed({{(SW-AW){1'b0}}, light_lo_q}) + SW'(step10),
                               adc_lo, adc_hi);
  assign soil_new  = clamp_adc($signed({{(SW-AW){1'b0}}, soil_lo_q}) + SW'(step10),
                               adc_lo, adc_hi);

  always_comb begin
    page_d     = page_q;
    temp_lo_d  = temp_lo_q;
    temp_hi_d  = temp_hi_q;
    humi_lo_d  = humi_lo_q;
    humi_hi_d  = humi_hi_q;
    air_max_d  = air_max_q;
    light_lo_d = light_lo_q;
    soil_lo_d  = soil_lo_q;
    temp_rd_d  = temp_rd_q;
    humi_rd_d  = humi_rd_q;
    air_rd_d   = air_rd_q;
    light_rd_d = light_rd_q;
    soil_rd_d  = soil_rd_q;
    case (item_i.command)
      tac_pkg::CMD_SENSOR: begin
        temp_rd_d  = item_i.temperature;
        humi_rd_d  = item_i.humidity;
        air_rd_d   = item_i.air_level;
        light_rd_d = item_i.light_level;
        soil_rd_d  = item_i.soil_moisture;
      end
      tac_pkg::CMD_NEXT_PAGE: begin
        page_d = (page_q == tac_pkg::PAGE_VALUES) ? tac_pkg::PAGE_THRESHOLDS
                                                  : tac_pkg::PAGE_VALUES;
      end
      tac_pkg::CMD_NEXT_ITEM: begin
        // wraps from the last setting page back to the first; a display page also goes to the first
        if (page_q < tac_pkg::PAGE_TEMP_LO || page_q >= tac_pkg::PAGE_SOIL_LO) begin
          page_d = tac_pkg::PAGE_TEMP_LO;
        end else begin
          page_d = tac_pkg::page_e'(page_q + 4'd1);
        end
      end
      tac_pkg::CMD_ADJUST: begin
        case (page_q)
          tac_pkg::PAGE_TEMP_LO:  temp_lo_d  = temp_lo_new[TW-1:0];
          tac_pkg::PAGE_TEMP_HI:  temp_hi_d  = temp_hi_new[TW-1:0];
          tac_pkg::PAGE_HUMI_LO:  humi_lo_d  = humi_lo_new[HW-1:0];
          tac_pkg::PAGE_HUMI_HI:  humi_hi_d  = humi_hi_new[HW-1:0];
          tac_pkg::PAGE_AIR_MAX:  air_max_d  = air_new[AW-1:0];
          tac_pkg::PAGE_LIGHT_LO: light_lo_d = light_new[AW-1:0];
          tac_pkg::PAGE_SOIL_LO:  soil_lo_d  = soil_new[AW-1:0];
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_q     <= tac_pkg::PAGE_VALUES;
      temp_lo_q  <= tac_pkg::DEF_TEMP_LO;
      temp_hi_q  <= tac_pkg::DEF_TEMP_HI;
      humi_lo_q  <= tac_pkg::DEF_HUMI_LO;
      humi_hi_q  <= tac_pkg::DEF_HUMI_HI;
      air_max_q  <= tac_pkg::DEF_AIR_MAX;
      light_lo_q <= tac_pkg::DEF_LIGHT_LO;
      soil_lo_q  <= tac_pkg::DEF_SOIL_LO;
      temp_rd_q  <= tac_pkg::RST_TEMP_READING;
      humi_rd_q  <= tac_pkg::RST_HUMI_READING;
      air_rd_q   <= tac_pkg::RST_AIR_READING;
      light_rd_q <= tac_pkg::RST_LIGHT_READING;
      soil_rd_q  <= tac_pkg::RST_SOIL_READING;
    end else if (fire) begin
      page_q     <= page_d;
      temp_lo_q  <= temp_lo_d;
      temp_hi_q  <= temp_hi_d;
      humi_lo_q  <= humi_lo_d;
      humi_hi_q  <= humi_hi_d;
      air_max_q  <= air_max_d;
      light_lo_q <= light_lo_d;
      soil_lo_q  <= soil_lo_d;
      temp_rd_q  <= temp_rd_d;
      humi_rd_q  <= humi_rd_d;
      air_rd_q   <= air_rd_d;
      light_rd_q <= light_rd_d;
      soil_rd_q  <= soil_rd_d;
    end
  end

  // alarms of the state after this word
  always_comb begin
    flags.temp_high_led = $signed(temp_rd_d) > $signed(temp_hi_d);
    flags.temp_low_led  = $signed(temp_rd_d) < $signed(temp_lo_d);
    flags.humi_high_led = humi_rd_d > humi_hi_d;
    flags.humi_low_led  = humi_rd_d < humi_lo_d;
    flags.pump_relay    = soil_rd_d < soil_lo_d;
    flags.fan_relay     = air_rd_d > air_max_d;
    flags.lamp_relay    = light_rd_d < light_lo_d;
    flags.buzzer_on     = flags.fan_relay;
  end

  assign result_o.flags        = flags;
  assign result_o.page         = page_d;
  assign result_o.setting_mode = page_d >= tac_pkg::PAGE_TEMP_LO;

endmodule

@@ rtl/threshold_alarm_controller_core.sv @@
// ----------------------------------------------------------------------------
// threshold_alarm_controller_core
// Greenhouse alarm controller: sensor readings, thresholds, ui page and
// alarm/relay outputs, one result word per command word.
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_ready_o   command .. soil_moisture
//   out      output     out_valid_o / out_ready_i temp_high_led .. setting_mode
//   cfg      input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// One word per cycle sustained while the output is not stalled; a result
// passes the input register, then update logic into the output register.
// State is written when a word leaves the input register, so the next word
// already sees it. A stalled output holds its word while the input register
// still takes one more. Reset restores limits, defaults and the values page.
// ----------------------------------------------------------------------------
module threshold_alarm_controller_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [1:0]                       command_i,
  input  logic signed [tac_pkg::DELTA_W-1:0] adjust_delta_i,
  input  logic signed [tac_pkg::TEMP_W-1:0]  temperature_i,
  input  logic [tac_pkg::HUMI_W-1:0]       humidity_i,
  input  logic [tac_pkg::ADC_BITS-1:0]     air_level_i,
  input  logic [tac_pkg::ADC_BITS-1:0]     light_level_i,
  input  logic [tac_pkg::ADC_BITS-1:0]     soil_moisture_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             temp_high_led_o,
  output logic                             temp_low_led_o,
  output logic                             humi_high_led_o,
  output logic                             humi_low_led_o,
  output logic                             pump_relay_o,
  output logic                             fan_relay_o,
  output logic                             lamp_relay_o,
  output logic                             buzzer_on_o,
  output logic [3:0]                       ui_page_o,
  output logic                             setting_mode_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [tac_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [tac_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  tac_pkg::item_t   in_item;
  tac_pkg::item_t   s1_item;
  logic             s1_valid;
  logic             advance;
  tac_pkg::result_t result;
  tac_pkg::result_t result_q;
  logic             out_valid_q;

  assign in_item.command       = tac_pkg::cmd_e'(command_i);
  assign in_item.adjust_delta  = adjust_delta_i;
  assign in_item.temperature   = temperature_i;
  assign in_item.humidity      = humidity_i;
  assign in_item.air_level     = air_level_i;
  assign in_item.light_level   = light_level_i;
  assign in_item.soil_moisture = soil_moisture_i;

  // output register free or draining this cycle
  assign advance = !out_valid_q || out_ready_i;

  tac_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .item_i       (in_item),
    .advance_i    (advance),
    .item_valid_o (s1_valid),
    .item_o       (s1_item)
  );

  tac_update u_update (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .item_valid_i (s1_valid),
    .advance_i    (advance),
    .item_i       (s1_item),
    .result_o     (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && s1_valid) begin
      result_q <= result;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign temp_high_led_o = result_q.flags.temp_high_led;
  assign temp_low_led_o  = result_q.flags.temp_low_led;
  assign humi_high_led_o = result_q.flags.humi_high_led;
  assign humi_low_led_o  = result_q.flags.humi_low_led;
  assign pump_relay_o    = result_q.flags.pump_relay;
  assign fan_relay_o     = result_q.flags.fan_relay;
  assign lamp_relay_o    = result_q.flags.lamp_relay;
  assign buzzer_on_o     = result_q.flags.buzzer_on;
  assign ui_page_o       = result_q.page;
  assign setting_mode_o  = result_q.setting_mode;

`ifndef SYNTH
  // setting flag follows the page and the page stays in range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (ui_page_o <= tac_pkg::PAGE_SOIL_LO) &&
                    (setting_mode_o == (ui_page_o >= tac_pkg::PAGE_TEMP_LO)))
    else $error("ui page or setting flag out of step");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (buzzer_on_o == fan_relay_o))
    else $error("buzzer differs from fan relay");

  // a taken word sits in the input register on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> s1_valid)
    else $error("accepted word lost");

  // a stalled output register keeps its word and no result is dropped
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i && s1_valid) |=> (out_valid_q && s1_valid))
    else $error("word dropped under stall");
`endif

endmodule

@@ bench/threshold_alarm_controller_core_tb.sv @@
// ----------------------------------------------------------------------------
// threshold_alarm_controller_core_tb
// Self-checking bench for the greenhouse alarm controller. A small model
// tracks readings, thresholds, limits and the ui page, and predicts the
// result word of every command word the core takes. Directed words cover
// the page walk, adjust clamping and sensor extremes. Random words then run
// under several limit settings, including crossed limits. The sender works
// in bursts, the receiver stalls at random, and one long receiver hold-off
// backs up the input side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module threshold_alarm_controller_core_tb;

  localparam int ADC_STEP_SCALE   = 10;
  localparam int WORDS_PER_PHASE  = 270;
  localparam int SETTLE_CYCLES    = 4;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int WATCHDOG_LIMIT   = 4000;
  localparam int ADC_W            = tac_pkg::ADC_BITS;
  localparam int CFG_W            = tac_pkg::CFG_DATA_W;
  localparam int IDX_W            = tac_pkg::CFG_IDX_W;
  localparam int TW               = tac_pkg::TEMP_W;
  localparam int HW               = tac_pkg::HUMI_W;

  // keeps the core's state and queues the result word each command should give
  class alarm_state_model;
    int temp_floor, temp_ceiling, humi_floor, humi_ceiling, adc_floor, adc_ceiling;
    tac_pkg::page_e page;
    int temp_lo, temp_hi, humi_lo, humi_hi, air_max, light_lo, soil_lo;
    int temp_now, humi_now, air_now, light_now, soil_now;
    tac_pkg::result_t pending_alarms[$];
    int errors, words_seen, results_checked, sensor_words, adjust_words;

    function new();
      temp_floor   = int'($signed(tac_pkg::RST_TEMP_FLOOR));
      temp_ceiling = int'($signed(tac_pkg::RST_TEMP_CEILING));
      humi_floor   = int'(tac_pkg::RST_HUMI_FLOOR);
      humi_ceiling = int'(tac_pkg::RST_HUMI_CEILING);
      adc_floor    = int'(tac_pkg::RST_ADC_FLOOR);
      adc_ceiling  = int'(tac_pkg::RST_ADC_CEILING);
      page         = tac_pkg::PAGE_VALUES;
      temp_lo      = int'($signed(tac_pkg::DEF_TEMP_LO));
      temp_hi      = int'($signed(tac_pkg::DEF_TEMP_HI));
      humi_lo      = int'(tac_pkg::DEF_HUMI_LO);
      humi_hi      = int'(tac_pkg::DEF_HUMI_HI);
      air_max      = int'(tac_pkg::DEF_AIR_MAX);
      light_lo     = int'(tac_pkg::DEF_LIGHT_LO);
      soil_lo      = int'(tac_pkg::DEF_SOIL_LO);
      temp_now     = int'($signed(tac_pkg::RST_TEMP_READING));
      humi_now     = int'(tac_pkg::RST_HUMI_READING);
      air_now      = int'(tac_pkg::RST_AIR_READING);
      light_now    = int'(tac_pkg::RST_LIGHT_READING);
      soil_now     = int'(tac_pkg::RST_SOIL_READING);
    endfunction

    // when the bounds cross, a value under the lower bound gets it, any other the upper
    function int clamp(int v, int lo, int hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    function void write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        tac_pkg::REG_TEMP_FLOOR:   temp_floor   = int'($signed(data[TW-1:0]));
        tac_pkg::REG_TEMP_CEILING: temp_ceiling = int'($signed(data[TW-1:0]));
        tac_pkg::REG_HUMI_FLOOR:   humi_floor   = int'(data[HW-1:0]);
        tac_pkg::REG_HUMI_CEILING: humi_ceiling = int'(data[HW-1:0]);
        tac_pkg::REG_ADC_FLOOR:    adc_floor    = int'(data[ADC_W-1:0]);
        tac_pkg::REG_ADC_CEILING:  adc_ceiling  = int'(data[ADC_W-1:0]);
        default: ;
      endcase
    endfunction

    function void take_word(tac_pkg::item_t w);
      tac_pkg::result_t r;
      int d;
      d = int'($signed(w.adjust_delta));
      case (w.command)
        tac_pkg::CMD_SENSOR: begin
          temp_now  = int'($signed(w.temperature));
          humi_now  = int'(w.humidity);
          air_now   = int'(w.air_level);
          light_now = int'(w.light_level);
          soil_now  = int'(w.soil_moisture);
          sensor_words++;
        end
        tac_pkg::CMD_NEXT_PAGE: begin
          page = (page == tac_pkg::PAGE_VALUES) ? tac_pkg::PAGE_THRESHOLDS
                                                : tac_pkg::PAGE_VALUES;
        end
        tac_pkg::CMD_NEXT_ITEM: begin
          if (page < tac_pkg::PAGE_TEMP_LO || page >= tac_pkg::PAGE_SOIL_LO) begin
            page = tac_pkg::PAGE_TEMP_LO;
          end else begin
            page = tac_pkg::page_e'(page + 1);
          end
        end
        default: begin
          adjust_words++;
          case (page)
            tac_pkg::PAGE_TEMP_LO: temp_lo = clamp(temp_lo + d, temp_floor, temp_hi);
            tac_pkg::PAGE_TEMP_HI: temp_hi = clamp(temp_hi + d, temp_lo, temp_ceiling);
            tac_pkg::PAGE_HUMI_LO: humi_lo = clamp(humi_lo + d, humi_floor, humi_hi);
            tac_pkg::PAGE_HUMI_HI: humi_hi = clamp(humi_hi + d, humi_lo, humi_ceiling);
            tac_pkg::PAGE_AIR_MAX:
              air_max = clamp(air_max + d * ADC_STEP_SCALE, adc_floor, adc_ceiling);
            tac_pkg::PAGE_LIGHT_LO:
              light_lo = clamp(light_lo + d * ADC_STEP_SCALE, adc_floor, adc_ceiling);
            tac_pkg::PAGE_SOIL_LO:
              soil_lo = clamp(soil_lo + d * ADC_STEP_SCALE, adc_floor, adc_ceiling);
            default: ;
          endcase
        end
      endcase
      r.flags.temp_high_led = temp_now > temp_hi;
      r.flags.temp_low_led  = temp_now < temp_lo;
      r.flags.humi_high_led = humi_now > humi_hi;
      r.flags.humi_low_led  = humi_now < humi_lo;
      r.flags.pump_relay    = soil_now < soil_lo;
      r.flags.fan_relay     = air_now > air_max;
      r.flags.lamp_relay    = light_now < light_lo;
      r.flags.buzzer_on     = r.flags.fan_relay;
      r.page                = page;
      r.setting_mode        = page >= tac_pkg::PAGE_TEMP_LO;
      pending_alarms.push_back(r);
      words_seen++;
    endfunction

    function void compare_field(string name, logic [3:0] exp, logic [3:0] act);
      if (act !== exp) begin
        errors++;
        $error("%s expected %0d actual %0d", name, exp, act);
      end
    endfunction

    function void match_result(tac_pkg::result_t act);
      tac_pkg::result_t exp;
      if (pending_alarms.size() == 0) begin
        errors++;
        $error("result word with no command word pending");
        return;
      end
      exp = pending_alarms.pop_front();
      results_checked++;
      compare_field("temp_high_led", exp.flags.temp_high_led, act.flags.temp_high_led);
      compare_field("temp_low_led", exp.flags.temp_low_led, act.flags.temp_low_led);
      compare_field("humi_high_led", exp.flags.humi_high_led, act.flags.humi_high_led);
      compare_field("humi_low_led", exp.flags.humi_low_led, act.flags.humi_low_led);
      compare_field("pump_relay", exp.flags.pump_relay, act.flags.pump_relay);
      compare_field("fan_relay", exp.flags.fan_relay, act.flags.fan_relay);
      compare_field("lamp_relay", exp.flags.lamp_relay, act.flags.lamp_relay);
      compare_field("buzzer_on", exp.flags.buzzer_on, act.flags.buzzer_on);
      compare_field("ui_page", exp.page, act.page);
      compare_field("setting_mode", exp.setting_mode, act.setting_mode);
    endfunction
  endclass

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic             in_valid_i  = 1'b0;
  logic             in_ready_o;
  tac_pkg::item_t   offer       = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_W-1:0] cfg_data_i  = '0;

  logic [1:0]                         command_i;
  logic signed [tac_pkg::DELTA_W-1:0] adjust_delta_i;
  logic signed [TW-1:0]               temperature_i;
  logic [HW-1:0]                      humidity_i;
  logic [ADC_W-1:0]                   air_level_i, light_level_i, soil_moisture_i;
  logic temp_high_led_o, temp_low_led_o, humi_high_led_o, humi_low_led_o;
  logic pump_relay_o, fan_relay_o, lamp_relay_o, buzzer_on_o, setting_mode_o;
  logic [3:0] ui_page_o;
  tac_pkg::result_t seen_word;

  assign command_i       = offer.command;
  assign adjust_delta_i  = offer.adjust_delta;
  assign temperature_i   = offer.temperature;
  assign humidity_i      = offer.humidity;
  assign air_level_i     = offer.air_level;
  assign light_level_i   = offer.light_level;
  assign soil_moisture_i = offer.soil_moisture;
  assign seen_word = {buzzer_on_o, lamp_relay_o, fan_relay_o, pump_relay_o,
                      humi_low_led_o, humi_high_led_o, temp_low_led_o, temp_high_led_o,
                      ui_page_o, setting_mode_o};

  threshold_alarm_controller_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .command_i       (command_i),
    .adjust_delta_i  (adjust_delta_i),
    .temperature_i   (temperature_i),
    .humidity_i      (humidity_i),
    .air_level_i     (air_level_i),
    .light_level_i   (light_level_i),
    .soil_moisture_i (soil_moisture_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .temp_high_led_o (temp_high_led_o),
    .temp_low_led_o  (temp_low_led_o),
    .humi_high_led_o (humi_high_led_o),
    .humi_low_led_o  (humi_low_led_o),
    .pump_relay_o    (pump_relay_o),
    .fan_relay_o     (fan_relay_o),
    .lamp_relay_o    (lamp_relay_o),
    .buzzer_on_o     (buzzer_on_o),
    .ui_page_o       (ui_page_o),
    .setting_mode_o  (setting_mode_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  alarm_state_model model = new();
  int  burst_left  = 1;
  bit  offering    = 1'b0;
  bit  hold_done   = 1'b0;
  int  settings    = 1;
  int  idle_cycles = 0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // all three channels are sampled before this edge's updates land
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) model.match_result(seen_word);
      if (in_valid_i && in_ready_o) model.take_word(offer);
      if (cfg_valid_i && cfg_ready_o) model.write_reg(cfg_index_i, cfg_data_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((out_valid_o && out_ready_i) || (in_valid_i && in_ready_o) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", idle_cycles);
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // receiver: segments with their own stall rate, plus one long hold-off
  initial begin : receiver
    int stall_pct;
    int seg_len;
    @(posedge rst_ni);
    forever begin
      if (!hold_done && model.words_seen > 700) begin
        repeat (LONG_HOLD_CYCLES) begin
          @(posedge clk_i);
          out_ready_i <= 1'b0;
        end
        hold_done = 1'b1;
      end else begin
        case ($urandom_range(3))
          0: stall_pct = 0;
          1: stall_pct = 20;
          2: stall_pct = 50;
          default: stall_pct = 90;
        endcase
        seg_len = $urandom_range(20, 150);
        repeat (seg_len) begin
          @(posedge clk_i);
          out_ready_i <= ($urandom_range(99) >= stall_pct);
        end
      end
    end
  end

  function automatic tac_pkg::item_t random_word();
    tac_pkg::item_t w;
    int pick;
    pick = $urandom_range(99);
    if (pick < 30) w.command = tac_pkg::CMD_SENSOR;
    else if (pick < 40) w.command = tac_pkg::CMD_NEXT_PAGE;
    else if (pick < 70) w.command = tac_pkg::CMD_NEXT_ITEM;
    else w.command = tac_pkg::CMD_ADJUST;
    w.adjust_delta  = $urandom_range(1) ? 8'($urandom) : 8'($urandom_range(24) - 12);
    w.temperature   = $urandom_range(1) ? 8'($urandom) : 8'($urandom_range(80) - 20);
    w.humidity      = 7'($urandom_range(127));
    w.air_level     = ADC_W'($urandom);
    w.light_level   = ADC_W'($urandom);
    w.soil_moisture = ADC_W'($urandom);
    return w;
  endfunction

  function automatic tac_pkg::item_t step_word(tac_pkg::cmd_e cmd, int delta);
    tac_pkg::item_t w;
    w = random_word();
    w.command = cmd;
    w.adjust_delta = 8'(delta);
    return w;
  endfunction

  function automatic tac_pkg::item_t sensor_word(int t, int h, int a, int l, int s);
    tac_pkg::item_t w;
    w = step_word(tac_pkg::CMD_SENSOR, $urandom_range(255));
    w.temperature   = 8'(t);
    w.humidity      = 7'(h);
    w.air_level     = ADC_W'(a);
    w.light_level   = ADC_W'(l);
    w.soil_moisture = ADC_W'(s);
    return w;
  endfunction

  task automatic send_word(tac_pkg::item_t w);
    int gap;
    offer      <= w;
    in_valid_i <= 1'b1;
    offering = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        offering = 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // stop offering and wait until every result word is back
  task automatic settle();
    if (offering) begin
      in_valid_i <= 1'b0;
      offering = 1'b0;
    end
    @(posedge clk_i);
    while (model.pending_alarms.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // writes all six limits, then the two unused indexes with junk
  task automatic apply_limits(int tf, int tc, int hf, int hc, int af, int ac);
    logic [CFG_W-1:0] data [8];
    foreach (data[i]) data[i] = CFG_W'($urandom);
    data[tac_pkg::REG_TEMP_FLOOR]   = CFG_W'({$urandom, 8'(tf)});
    data[tac_pkg::REG_TEMP_CEILING] = CFG_W'({$urandom, 8'(tc)});
    data[tac_pkg::REG_HUMI_FLOOR]   = CFG_W'({$urandom, 7'(hf)});
    data[tac_pkg::REG_HUMI_CEILING] = CFG_W'({$urandom, 7'(hc)});
    data[tac_pkg::REG_ADC_FLOOR]    = CFG_W'(af);
    data[tac_pkg::REG_ADC_CEILING]  = CFG_W'(ac);
    for (int i = 0; i < 8; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= IDX_W'(i);
      cfg_data_i  <= data[i];
      do @(posedge clk_i); while (!cfg_ready_o);
    end
    cfg_valid_i <= 1'b0;
    settings++;
  endtask

  initial begin : stimulus
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // sensor extremes: high alarms and all relays on, then low alarms on and relays off
    send_word(sensor_word(127, 127, 4095, 0, 0));
    send_word(sensor_word(-128, 0, 0, 4095, 4095));
    // adjust on the display pages leaves thresholds alone
    send_word(step_word(tac_pkg::CMD_ADJUST, 127));
    send_word(step_word(tac_pkg::CMD_NEXT_PAGE, 0));
    send_word(step_word(tac_pkg::CMD_ADJUST, -128));
    send_word(step_word(tac_pkg::CMD_NEXT_PAGE, 0));
    // next item from values, next page from a setting page, next item from thresholds
    send_word(step_word(tac_pkg::CMD_NEXT_ITEM, 0));
    send_word(step_word(tac_pkg::CMD_NEXT_PAGE, 0));
    send_word(step_word(tac_pkg::CMD_NEXT_PAGE, 0));
    send_word(step_word(tac_pkg::CMD_NEXT_ITEM, 0));
    // walk the setting pages, pushing each threshold into its bounds
    send_word(step_word(tac_pkg::CMD_ADJUST, -128));
    send_word(step_word(tac_pkg::CMD_ADJUST, 127));
    send_word(step_word(tac_pkg::CMD_NEXT_ITEM, 0));
    send_word(step_word(tac_pkg::CMD_ADJUST, 127));
    send_word(step_word(tac_pkg::CMD_ADJUST, -128));
    send_word(step_word(tac_pkg::CMD_NEXT_ITEM, 0));
    send_word(step_word(tac_pkg::CMD_ADJUST, -128));
    send_word(step_word(tac_pkg::CMD_NEXT_ITEM, 0));
    send_word(step_word(tac_pkg::CMD_ADJUST, 127));
    send_word(step_word(tac_pkg::CMD_NEXT_ITEM, 0));
    send_word(step_word(tac_pkg::CMD_ADJUST, 127));
    send_word(step_word(tac_pkg::CMD_ADJUST, -128));
    send_word(step_word(tac_pkg::CMD_NEXT_ITEM, 0));
    send_word(step_word(tac_pkg::CMD_ADJUST, -128));
    send_word(step_word(tac_pkg::CMD_NEXT_ITEM, 0));
    send_word(step_word(tac_pkg::CMD_ADJUST, 127));
    // soil page wraps back to the first setting page
    send_word(step_word(tac_pkg::CMD_NEXT_ITEM, 0));

    for (int phase = 0; phase < 7; phase++) begin
      if (phase > 0) begin
        settle();
        case (phase)
          1: apply_limits(-128, 127, 0, 127, 0, 4095);
          2: apply_limits(0, 40, 20, 60, 500, 3000);
          3: apply_limits(100, -100, 90, 10, 4095, 0);
          6: apply_limits(-40, 125, 0, 100, 0, 4095);
          default: apply_limits($urandom_range(255) - 128, $urandom_range(255) - 128,
                                $urandom_range(127), $urandom_range(127),
                                $urandom_range(4095), $urandom_range(4095));
        endcase
      end
      repeat (WORDS_PER_PHASE) send_word(random_word());
    end

    settle();
    $display("covered %0d command words (%0d sensor, %0d adjust) over %0d limit settings",
             model.words_seen, model.sensor_words, model.adjust_words, settings);
    $display("checked %0d result words, %0d mismatches", model.results_checked,
             model.errors);
    if (model.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ threshold_alarm_controller_core.f @@
rtl/tac_pkg.sv
rtl/tac_in_stage.sv
rtl/tac_update.sv
rtl/threshold_alarm_controller_core.sv
bench/threshold_alarm_controller_core_tb.sv
